@@ hw/rtl/bgp_message_deframer_top_defines.svh @@
// ----------------------------------------------------------------------------
// BGP message deframer assertion macros
// Shared macros for the concurrent checks of the deframer.
// ----------------------------------------------------------------------------
`ifndef BGP_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define BGP_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BGPMD_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgpmd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BGPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgpmd assertion failed");

`endif

@@ hw/rtl/bgpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// BGP message deframer package
// Constants, codes and shared types of the deframer.
// ----------------------------------------------------------------------------
package bgpmd_pkg;

    localparam int HEADER_BYTES = 19;

    localparam int          REG_IDX_W      = 3;
    localparam logic [2:0]  REG_MAX_LEN    = 3'd0;
    localparam logic [2:0]  REG_OPEN_MIN   = 3'd1;
    localparam logic [2:0]  REG_UPDATE_MIN = 3'd2;
    localparam logic [2:0]  REG_NOTIFY_MIN = 3'd3;
    localparam logic [2:0]  REG_REFRESH_MIN = 3'd4;
    localparam logic [2:0]  REG_CAP_MIN    = 3'd5;

    localparam logic [15:0] RST_MAX_LEN     = 16'd4096;
    localparam logic [15:0] RST_OPEN_MIN    = 16'd29;
    localparam logic [15:0] RST_UPDATE_MIN  = 16'd23;
    localparam logic [15:0] RST_NOTIFY_MIN  = 16'd21;
    localparam logic [15:0] RST_REFRESH_MIN = 16'd23;
    localparam logic [15:0] RST_CAP_MIN     = 16'd19;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [7:0] MARKER_BYTE = 8'hff;

    localparam logic [7:0] MSG_OPEN        = 8'd1;
    localparam logic [7:0] MSG_UPDATE      = 8'd2;
    localparam logic [7:0] MSG_NOTIFY      = 8'd3;
    localparam logic [7:0] MSG_KEEPALIVE   = 8'd4;
    localparam logic [7:0] MSG_REFRESH     = 8'd5;
    localparam logic [7:0] MSG_CAPABILITY  = 8'd6;
    localparam logic [7:0] MSG_REFRESH_OLD = 8'd128;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MARKER = 2'd1;
    localparam logic [1:0] ERR_TYPE   = 2'd2;
    localparam logic [1:0] ERR_LENGTH = 2'd3;

    typedef struct packed {
        logic [15:0] max_len;
        logic [15:0] open_min;
        logic [15:0] update_min;
        logic [15:0] notify_min;
        logic [15:0] refresh_min;
        logic [15:0] cap_min;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  code;
        logic [15:0] data;
    } t_chk;

endpackage

@@ hw/rtl/bgpmd_in_if.sv @@
// ----------------------------------------------------------------------------
// Deframer input channel
// Stream words: an operation bit and one stream byte.
// ----------------------------------------------------------------------------
interface bgpmd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, op, data_byte, input ready);
    modport sink (input valid, op, data_byte, output ready);
endinterface

@@ hw/rtl/bgpmd_out_if.sv @@
// ----------------------------------------------------------------------------
// Deframer output channel
// Message bytes with framing flags, header fields and error report.
// ----------------------------------------------------------------------------
interface bgpmd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        first_of_message;
    logic        last_of_message;
    logic [7:0]  message_type;
    logic [15:0] message_length;
    logic [1:0]  error_code;
    logic [15:0] error_data;
    logic        last_in_run;

    modport source (
        output valid, out_byte, first_of_message, last_of_message, message_type,
               message_length, error_code, error_data, last_in_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, first_of_message, last_of_message, message_type,
               message_length, error_code, error_data, last_in_run,
        output ready
    );
endinterface

@@ hw/rtl/bgpmd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Deframer configuration channel
// Register writes: a register index and a 16-bit data word.
// ----------------------------------------------------------------------------
interface bgpmd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bgpmd_pkg::REG_IDX_W-1:0]  index;
    logic [15:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bgp_message_deframer_top.sv @@
// ----------------------------------------------------------------------------
// BGP message deframer
// Takes one stream byte per word and gathers the header in a small memory.
// Header bytes are taken at one per cycle, body bytes at one per cycle
// while the output is not stalled. After the last header byte the input
// holds while the header is checked; a valid header then holds it while
// the stored header is read back from the header memory, one entry per
// cycle while the output is not stalled, and sent as 19 output words.
// A bad header gives one error word after the check cycle, and stream bytes
// are then dropped until a restart word. Configuration writes are taken at
// any time and should be made only while the block is idle.
// ----------------------------------------------------------------------------
`include "bgp_message_deframer_top_defines.svh"

module bgp_message_deframer_top #(
    parameter int HEADER_BYTES = bgpmd_pkg::HEADER_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bgpmd_in_if.sink     i_in,
    bgpmd_out_if.source  o_out,
    bgpmd_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(HEADER_BYTES);
    localparam int IW = $clog2(HEADER_BYTES + 1);

    localparam logic [15:0]   HDR_LEN    = 16'(HEADER_BYTES);
    localparam logic [15:0]   POS_LEN_HI = 16'(HEADER_BYTES - 3);
    localparam logic [15:0]   POS_LEN_LO = 16'(HEADER_BYTES - 2);
    localparam logic [15:0]   POS_TYPE   = 16'(HEADER_BYTES - 1);
    localparam logic [IW-1:0] BURST_LAST = IW'(HEADER_BYTES - 1);
    localparam logic [IW-1:0] BURST_END  = IW'(HEADER_BYTES);

    localparam logic [2:0] ST_HDR   = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_BURST = 3'd2;
    localparam logic [2:0] ST_BODY  = 3'd3;
    localparam logic [2:0] ST_HALT  = 3'd4;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        first;
        logic        last;
        logic [7:0]  msg_type;
        logic [15:0] msg_len;
        logic [1:0]  code;
        logic [15:0] edata;
        logic        lir;
    } t_res;

    logic [2:0]    r_state,     n_state;
    logic [15:0]   r_count,     n_count;
    logic          r_mok,       n_mok;
    logic [15:0]   r_hdr_len,   n_hdr_len;
    logic [7:0]    r_hdr_type,  n_hdr_type;
    logic [15:0]   r_cur_len,   n_cur_len;
    logic [7:0]    r_cur_type,  n_cur_type;
    logic [IW-1:0] r_issue_idx, n_issue_idx;
    logic [IW-1:0] r_emit_idx,  n_emit_idx;
    logic          r_rd_pend,   n_rd_pend;
    logic          r_out_valid, n_out_valid;
    t_res          r_out,       n_out;

    bgpmd_pkg::t_cfg cfg;
    bgpmd_pkg::t_chk chk;

    logic        in_ready;
    logic        out_free;
    logic        out_load;
    logic        ram_we;
    logic        ram_re;
    logic [7:0]  ram_rdata;
    logic [15:0] cnt_inc;
    logic        body_end;

    bgpmd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bgpmd_hdr_check #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hdr_check (
        .i_marker_ok (r_mok),
        .i_type      (r_hdr_type),
        .i_len       (r_hdr_len),
        .i_cfg       (cfg),
        .o_chk       (chk)
    );

    bgpmd_ram #(
        .WIDTH (8),
        .DEPTH (HEADER_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_re    (ram_re),
        .i_raddr (r_issue_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = in_ready;
    assign cnt_inc    = r_count + 16'd1;
    assign body_end   = (cnt_inc >= r_cur_len);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mok       = r_mok;
        n_hdr_len   = r_hdr_len;
        n_hdr_type  = r_hdr_type;
        n_cur_len   = r_cur_len;
        n_cur_type  = r_cur_type;
        n_issue_idx = r_issue_idx;
        n_emit_idx  = r_emit_idx;
        n_rd_pend   = r_rd_pend;
        n_out       = r_out;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (r_state)
            ST_HDR: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.op == bgpmd_pkg::OP_RESTART) begin
                        n_count = 16'd0;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = cnt_inc;
                        if (r_count == 16'd0) begin
                            n_mok = (i_in.data_byte == bgpmd_pkg::MARKER_BYTE);
                        end else if (r_count < POS_LEN_HI) begin
                            n_mok = r_mok && (i_in.data_byte == bgpmd_pkg::MARKER_BYTE);
                        end
                        if (r_count == POS_LEN_HI) begin
                            n_hdr_len[15:8] = i_in.data_byte;
                        end
                        if (r_count == POS_LEN_LO) begin
                            n_hdr_len[7:0] = i_in.data_byte;
                        end
                        if (r_count == POS_TYPE) begin
                            n_hdr_type = i_in.data_byte;
                            n_state    = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (chk.code != bgpmd_pkg::ERR_NONE) begin
                    if (out_free) begin
                        out_load       = 1'b1;
                        n_out.out_byte = 8'd0;
                        n_out.first    = 1'b0;
                        n_out.last     = 1'b0;
                        n_out.msg_type = r_hdr_type;
                        n_out.msg_len  = r_hdr_len;
                        n_out.code     = chk.code;
                        n_out.edata    = chk.data;
                        n_out.lir      = 1'b1;
                        n_count        = 16'd0;
                        n_state        = ST_HALT;
                    end
                end else begin
                    n_cur_len   = r_hdr_len;
                    n_cur_type  = r_hdr_type;
                    n_issue_idx = '0;
                    n_emit_idx  = '0;
                    n_rd_pend   = 1'b0;
                    n_state     = ST_BURST;
                    if (r_hdr_len == HDR_LEN) begin
                        n_count = 16'd0;
                    end
                end
            end
            ST_BURST: begin
                out_load = r_rd_pend && out_free;
                ram_re   = (r_issue_idx != BURST_END) && (!r_rd_pend || out_load);
                if (ram_re) begin
                    n_issue_idx = r_issue_idx + IW'(1);
                    n_rd_pend   = 1'b1;
                end else if (out_load) begin
                    n_rd_pend = 1'b0;
                end
                if (out_load) begin
                    n_out.out_byte = ram_rdata;
                    n_out.first    = (r_emit_idx == '0);
                    n_out.last     = (r_emit_idx == BURST_LAST) && (r_cur_len == HDR_LEN);
                    n_out.msg_type = r_cur_type;
                    n_out.msg_len  = r_cur_len;
                    n_out.code     = bgpmd_pkg::ERR_NONE;
                    n_out.edata    = 16'd0;
                    n_out.lir      = (r_emit_idx == BURST_LAST);
                    n_emit_idx     = r_emit_idx + IW'(1);
                    if (r_emit_idx == BURST_LAST) begin
                        n_state = (r_cur_len == HDR_LEN) ? ST_HDR : ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                in_ready = out_free;
                if (i_in.valid && out_free) begin
                    if (i_in.op == bgpmd_pkg::OP_RESTART) begin
                        n_count = 16'd0;
                        n_state = ST_HDR;
                    end else begin
                        out_load       = 1'b1;
                        n_out.out_byte = i_in.data_byte;
                        n_out.first    = 1'b0;
                        n_out.last     = body_end;
                        n_out.msg_type = r_cur_type;
                        n_out.msg_len  = r_cur_len;
                        n_out.code     = bgpmd_pkg::ERR_NONE;
                        n_out.edata    = 16'd0;
                        n_out.lir      = 1'b1;
                        if (body_end) begin
                            n_count = 16'd0;
                            n_state = ST_HDR;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
            end
            ST_HALT: begin
                in_ready = 1'b1;
                if (i_in.valid && (i_in.op == bgpmd_pkg::OP_RESTART)) begin
                    n_count = 16'd0;
                    n_state = ST_HDR;
                end
            end
            default: begin
                n_state = ST_HDR;
                n_count = 16'd0;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HDR;
            r_count     <= 16'd0;
            r_mok       <= 1'b0;
            r_cur_len   <= 16'd0;
            r_cur_type  <= 8'd0;
            r_issue_idx <= '0;
            r_emit_idx  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mok       <= n_mok;
            r_cur_len   <= n_cur_len;
            r_cur_type  <= n_cur_type;
            r_issue_idx <= n_issue_idx;
            r_emit_idx  <= n_emit_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_len  <= n_hdr_len;
        r_hdr_type <= n_hdr_type;
        r_out      <= n_out;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.out_byte         = r_out.out_byte;
    assign o_out.first_of_message = r_out.first;
    assign o_out.last_of_message  = r_out.last;
    assign o_out.message_type     = r_out.msg_type;
    assign o_out.message_length   = r_out.msg_len;
    assign o_out.error_code       = r_out.code;
    assign o_out.error_data       = r_out.edata;
    assign o_out.last_in_run      = r_out.lir;

    `BGPMD_ASSERT(a_hdr_count, i_clk, i_rst_n, r_state == ST_HDR, r_count < HDR_LEN)
    `BGPMD_ASSERT(a_body_count, i_clk, i_rst_n, r_state == ST_BODY, (r_count >= HDR_LEN) && (r_count < r_cur_len))
    `BGPMD_ASSERT(a_pend_in_burst, i_clk, i_rst_n, r_rd_pend, r_state == ST_BURST)
    `BGPMD_ASSERT(a_no_overwrite, i_clk, i_rst_n, out_load, !r_out_valid || o_out.ready)
    `BGPMD_ASSERT_NEXT(a_error_halts, i_clk, i_rst_n, (r_state == ST_CHECK) && (chk.code != bgpmd_pkg::ERR_NONE) && out_free, (r_state == ST_HALT) && r_out_valid)

endmodule

@@ hw/rtl/bgpmd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module bgpmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bgpmd_pkg::HEADER_BYTES,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bgpmd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the maximum length and the per-type minimum lengths.
// ----------------------------------------------------------------------------
module bgpmd_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bgpmd_cfg_if.sink           i_cfg,
    output bgpmd_pkg::t_cfg     o_cfg
);

    bgpmd_pkg::t_cfg r_cfg;
    bgpmd_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                bgpmd_pkg::REG_MAX_LEN:     n_cfg.max_len     = i_cfg.data;
                bgpmd_pkg::REG_OPEN_MIN:    n_cfg.open_min    = i_cfg.data;
                bgpmd_pkg::REG_UPDATE_MIN:  n_cfg.update_min  = i_cfg.data;
                bgpmd_pkg::REG_NOTIFY_MIN:  n_cfg.notify_min  = i_cfg.data;
                bgpmd_pkg::REG_REFRESH_MIN: n_cfg.refresh_min = i_cfg.data;
                bgpmd_pkg::REG_CAP_MIN:     n_cfg.cap_min     = i_cfg.data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len     <= bgpmd_pkg::RST_MAX_LEN;
            r_cfg.open_min    <= bgpmd_pkg::RST_OPEN_MIN;
            r_cfg.update_min  <= bgpmd_pkg::RST_UPDATE_MIN;
            r_cfg.notify_min  <= bgpmd_pkg::RST_NOTIFY_MIN;
            r_cfg.refresh_min <= bgpmd_pkg::RST_REFRESH_MIN;
            r_cfg.cap_min     <= bgpmd_pkg::RST_CAP_MIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/bgpmd_hdr_check.sv @@
// ----------------------------------------------------------------------------
// Deframer header check
// Checks marker, type and length of a gathered header, in that order.
// ----------------------------------------------------------------------------
module bgpmd_hdr_check #(
    parameter int HEADER_BYTES = bgpmd_pkg::HEADER_BYTES
) (
    input  logic             i_marker_ok,
    input  logic [7:0]       i_type,
    input  logic [15:0]      i_len,
    input  bgpmd_pkg::t_cfg  i_cfg,
    output bgpmd_pkg::t_chk  o_chk
);

    localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

    logic [15:0] min_len;
    logic        type_ok;
    logic        len_bad;

    always_comb begin
        min_len = HDR_LEN;
        type_ok = 1'b1;
        case (i_type)
            bgpmd_pkg::MSG_OPEN:        min_len = i_cfg.open_min;
            bgpmd_pkg::MSG_UPDATE:      min_len = i_cfg.update_min;
            bgpmd_pkg::MSG_NOTIFY:      min_len = i_cfg.notify_min;
            bgpmd_pkg::MSG_KEEPALIVE:   min_len = HDR_LEN;
            bgpmd_pkg::MSG_REFRESH:     min_len = i_cfg.refresh_min;
            bgpmd_pkg::MSG_REFRESH_OLD: min_len = i_cfg.refresh_min;
            bgpmd_pkg::MSG_CAPABILITY:  min_len = i_cfg.cap_min;
            default:                    type_ok = 1'b0;
        endcase

        len_bad = (i_len < HDR_LEN) || (i_len > i_cfg.max_len) || (i_len < min_len)
               || ((i_type == bgpmd_pkg::MSG_KEEPALIVE) && (i_len != HDR_LEN));

        o_chk.code = bgpmd_pkg::ERR_NONE;
        o_chk.data = 16'd0;
        if (!i_marker_ok) begin
            o_chk.code = bgpmd_pkg::ERR_MARKER;
        end else if (!type_ok) begin
            o_chk.code = bgpmd_pkg::ERR_TYPE;
            o_chk.data = {8'd0, i_type};
        end else if (len_bad) begin
            o_chk.code = bgpmd_pkg::ERR_LENGTH;
            o_chk.data = i_len;
        end
    end

endmodule

@@ dv/tb_bgpmd_sb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGP deframer scoreboard
// Tracks header gathering, header checks and body counting for each accepted
// stream word, queues the output words this should cause and compares every
// output word field by field against the oldest one queued.
// ----------------------------------------------------------------------------
package tb_bgpmd_sb_pkg;

    import bgpmd_pkg::*;

    localparam int MARKER_BYTES = 16;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        first_of_message;
        logic        last_of_message;
        logic [7:0]  message_type;
        logic [15:0] message_length;
        logic [1:0]  error_code;
        logic [15:0] error_data;
        logic        last_in_run;
    } t_out_word;

    class deframer_scoreboard;

        t_cfg        limits;
        logic [7:0]  hdr [HEADER_BYTES];
        logic [15:0] taken;
        logic [15:0] cur_len;
        logic [7:0]  cur_type;
        bit          halted;
        t_out_word   due_words [$];
        int          mismatches;

        function new();
            limits = '{RST_MAX_LEN, RST_OPEN_MIN, RST_UPDATE_MIN, RST_NOTIFY_MIN,
                       RST_REFRESH_MIN, RST_CAP_MIN};
            taken = '0;
            cur_len = '0;
            cur_type = '0;
            halted = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] index, logic [15:0] value);
            case (index)
                REG_MAX_LEN:     limits.max_len = value;
                REG_OPEN_MIN:    limits.open_min = value;
                REG_UPDATE_MIN:  limits.update_min = value;
                REG_NOTIFY_MIN:  limits.notify_min = value;
                REG_REFRESH_MIN: limits.refresh_min = value;
                REG_CAP_MIN:     limits.cap_min = value;
                default: ;
            endcase
        endfunction

        // Smallest length allowed for a type, or -1 where the type is unknown.
        function int min_length(logic [7:0] kind);
            case (kind)
                MSG_OPEN:                     return limits.open_min;
                MSG_UPDATE:                   return limits.update_min;
                MSG_NOTIFY:                   return limits.notify_min;
                MSG_KEEPALIVE:                return HEADER_BYTES;
                MSG_REFRESH, MSG_REFRESH_OLD: return limits.refresh_min;
                MSG_CAPABILITY:               return limits.cap_min;
                default:                      return -1;
            endcase
        endfunction

        function void queue_word(logic [7:0] b, logic first, logic last, logic [7:0] kind,
                                 logic [15:0] len, logic [1:0] code, logic [15:0] detail,
                                 logic run_end);
            t_out_word w;
            w.out_byte = b;
            w.first_of_message = first;
            w.last_of_message = last;
            w.message_type = kind;
            w.message_length = len;
            w.error_code = code;
            w.error_data = detail;
            w.last_in_run = run_end;
            due_words.push_back(w);
        endfunction

        function void take_stream_word(logic op, logic [7:0] b);
            logic [15:0] len;
            logic [7:0]  kind;
            logic [1:0]  code;
            logic [15:0] detail;
            int          floor_len;
            if (op == OP_RESTART) begin
                taken = '0;
                halted = 1'b0;
                return;
            end
            if (halted) return;
            if (taken < HEADER_BYTES) begin
                hdr[taken] = b;
                taken++;
                if (taken < HEADER_BYTES) return;
                len = {hdr[MARKER_BYTES], hdr[MARKER_BYTES + 1]};
                kind = hdr[MARKER_BYTES + 2];
                code = ERR_NONE;
                for (int i = 0; i < MARKER_BYTES; i++) begin
                    if (hdr[i] != MARKER_BYTE) code = ERR_MARKER;
                end
                floor_len = min_length(kind);
                if (code == ERR_NONE && floor_len < 0) begin
                    code = ERR_TYPE;
                end else if (code == ERR_NONE && (len < HEADER_BYTES || len > limits.max_len
                        || len < floor_len || (kind == MSG_KEEPALIVE && len != HEADER_BYTES))) begin
                    code = ERR_LENGTH;
                end
                if (code != ERR_NONE) begin
                    detail = (code == ERR_TYPE) ? {8'd0, kind} :
                             (code == ERR_LENGTH) ? len : 16'd0;
                    queue_word(8'd0, 1'b0, 1'b0, kind, len, code, detail, 1'b1);
                    halted = 1'b1;
                    taken = '0;
                    return;
                end
                cur_len = len;
                cur_type = kind;
                for (int k = 0; k < HEADER_BYTES; k++) begin
                    queue_word(hdr[k], k == 0, k == HEADER_BYTES - 1 && len == HEADER_BYTES,
                               kind, len, ERR_NONE, 16'd0, k == HEADER_BYTES - 1);
                end
                if (len == HEADER_BYTES) taken = '0;
                return;
            end
            taken++;
            queue_word(b, 1'b0, taken >= cur_len, cur_type, cur_len, ERR_NONE, 16'd0, 1'b1);
            if (taken >= cur_len) taken = '0;
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp) begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_out_word(t_out_word act);
            t_out_word exp;
            if (due_words.size() == 0) begin
                $display("%0t: output word expected none, got %p", $time, act);
                mismatches++;
                return;
            end
            exp = due_words.pop_front();
            compare_field("out_byte", exp.out_byte, act.out_byte);
            compare_field("first_of_message", exp.first_of_message, act.first_of_message);
            compare_field("last_of_message", exp.last_of_message, act.last_of_message);
            compare_field("message_type", exp.message_type, act.message_type);
            compare_field("message_length", exp.message_length, act.message_length);
            compare_field("error_code", exp.error_code, act.error_code);
            compare_field("error_data", exp.error_data, act.error_data);
            compare_field("last_in_run", exp.last_in_run, act.last_in_run);
        endfunction

    endclass

endpackage

@@ dv/tb_bgp_message_deframer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGP message deframer testbench
// Feeds framed BGP messages, broken headers, cut messages and restarts under
// several limit settings, with random gaps on both channels, and checks every
// output word against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_bgp_message_deframer_top;

    import bgpmd_pkg::*;
    import tb_bgpmd_sb_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 3000;
    localparam logic [7:0] KNOWN_TYPES [7] = '{MSG_OPEN, MSG_UPDATE, MSG_NOTIFY,
        MSG_KEEPALIVE, MSG_REFRESH, MSG_CAPABILITY, MSG_REFRESH_OLD};

    logic i_clk = 1'b0;
    logic i_rst_n;

    bgpmd_in_if  in_if ();
    bgpmd_out_if out_if ();
    bgpmd_cfg_if cfg_if ();

    deframer_scoreboard sb;
    int fed;
    bit calm;
    bit src_gaps;

    bgp_message_deframer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic drain(int extra);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_words.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic send_word(logic op, logic [7:0] value);
        if (!calm && $urandom_range(0, 80) == 0) drain(0);
        if (!calm && src_gaps && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        fed++;
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.data_byte <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.take_stream_word(op, value);
    endtask

    task automatic program_limits(t_cfg setting);
        logic [REG_IDX_W-1:0] idx [6];
        logic [15:0]          val [6];
        idx = '{REG_MAX_LEN, REG_OPEN_MIN, REG_UPDATE_MIN, REG_NOTIFY_MIN,
                REG_REFRESH_MIN, REG_CAP_MIN};
        val = '{setting.max_len, setting.open_min, setting.update_min,
                setting.notify_min, setting.refresh_min, setting.cap_min};
        for (int i = 0; i < 6; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data <= val[i];
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // A header cut short or a body cut short ends in a restart, as does a
    // rejected header after up to three further bytes, which are dropped.
    task automatic send_message(logic [7:0] kind, logic [15:0] len, int broken_at,
                                int header_bytes, int body_bytes);
        logic [7:0] frame [HEADER_BYTES];
        for (int i = 0; i < MARKER_BYTES; i++) begin
            frame[i] = (i == broken_at) ? 8'($urandom_range(0, 254)) : MARKER_BYTE;
        end
        frame[MARKER_BYTES] = len[15:8];
        frame[MARKER_BYTES + 1] = len[7:0];
        frame[MARKER_BYTES + 2] = kind;
        for (int i = 0; i < header_bytes; i++) send_word(OP_BYTE, frame[i]);
        if (header_bytes < HEADER_BYTES) begin
            send_word(OP_RESTART, 8'($urandom));
            return;
        end
        if (sb.halted) begin
            repeat ($urandom_range(0, 3)) send_word(OP_BYTE, 8'($urandom));
            send_word(OP_RESTART, 8'($urandom));
        end else begin
            for (int i = 0; i < body_bytes; i++) send_word(OP_BYTE, 8'($urandom));
            if (body_bytes + HEADER_BYTES < len) send_word(OP_RESTART, 8'($urandom));
        end
    endtask

    task automatic random_message();
        logic [7:0] kind;
        int floor_len;
        int ceil_len;
        int len;
        int broken_at;
        int header_bytes;
        int body_bytes;
        int roll;
        roll = $urandom_range(0, 99);
        src_gaps = $urandom_range(0, 3) != 0;
        kind = KNOWN_TYPES[$urandom_range(0, 6)];
        floor_len = sb.min_length(kind);
        if (floor_len < HEADER_BYTES) floor_len = HEADER_BYTES;
        ceil_len = (kind == MSG_KEEPALIVE) ? HEADER_BYTES : floor_len + 6;
        if (ceil_len > sb.limits.max_len) ceil_len = sb.limits.max_len;
        len = (floor_len <= ceil_len) ? $urandom_range(floor_len, ceil_len) : floor_len;
        broken_at = -1;
        header_bytes = HEADER_BYTES;
        if (roll < 6) begin
            broken_at = $urandom_range(0, MARKER_BYTES - 1);
        end else if (roll < 12) begin
            kind = 8'($urandom);
            if (sb.min_length(kind) >= 0) kind = 8'd0;
        end else if (roll < 18) begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, HEADER_BYTES - 1)
                                              : $urandom_range(0, 65535);
        end else if (roll < 24) begin
            header_bytes = $urandom_range(1, HEADER_BYTES - 1);
        end else if (roll < 28) begin
            send_word(OP_RESTART, 8'($urandom));
            return;
        end
        body_bytes = (len > HEADER_BYTES) ? len - HEADER_BYTES : 0;
        if (body_bytes > 24) begin
            body_bytes = $urandom_range(0, 6);
        end else if (roll >= 28 && roll < 34 && body_bytes > 0) begin
            body_bytes = $urandom_range(0, body_bytes - 1);
        end
        send_message(kind, 16'(len), broken_at, header_bytes, body_bytes);
    endtask

    initial begin : stimulus
        t_cfg setting;
        int   phase_end;
        sb = new();
        fed = 0;
        calm = 1'b0;
        src_gaps = 1'b1;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.op <= OP_BYTE;
        in_if.data_byte <= 8'd0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_MAX_LEN;
        cfg_if.data <= 16'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_RESTART, 8'hff);
        send_message(MSG_KEEPALIVE, 16'd19, -1, HEADER_BYTES, 0);
        send_message(MSG_OPEN, 16'd29, -1, HEADER_BYTES, 10);
        send_message(MSG_REFRESH_OLD, 16'd23, -1, HEADER_BYTES, 4);
        send_message(MSG_OPEN, 16'd28, -1, HEADER_BYTES, 0);
        send_message(8'd7, 16'd19, -1, HEADER_BYTES, 0);
        send_message(MSG_KEEPALIVE, 16'd19, MARKER_BYTES - 1, HEADER_BYTES, 0);
        send_message(MSG_KEEPALIVE, 16'd19, -1, 10, 0);
        send_message(MSG_OPEN, 16'd40, -1, HEADER_BYTES, 5);

        drain(SETTLE_CYCLES);
        program_limits('{16'hffff, 16'd19, 16'd19, 16'd19, 16'd19, 16'd19});
        send_message(MSG_UPDATE, 16'hffff, -1, HEADER_BYTES, 3);
        send_message(MSG_OPEN, 16'd19, -1, HEADER_BYTES, 0);

        while (fed < 240) random_message();
        drain(SETTLE_CYCLES);
        program_limits('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
        while (fed < 262) random_message();
        drain(SETTLE_CYCLES);
        program_limits('{16'd0, 16'd19, 16'd19, 16'd19, 16'd19, 16'd19});
        while (fed < 284) random_message();

        while (fed < 335) begin
            drain(SETTLE_CYCLES);
            setting.max_len = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(19, 80));
            setting.open_min = 16'($urandom_range(19, 40));
            setting.update_min = 16'($urandom_range(19, 40));
            setting.notify_min = 16'($urandom_range(19, 40));
            setting.refresh_min = 16'($urandom_range(19, 40));
            setting.cap_min = 16'($urandom_range(19, 40));
            program_limits(setting);
            phase_end = fed + 25;
            while (fed < phase_end) random_message();
        end

        calm = 1'b1;
        while (fed < 360) random_message();

        drain(SETTLE_CYCLES);
        if (sb.mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin : result_sink
        t_out_word got;
        int        hold;
        int        stretch;
        bit        sink_gaps;
        hold = 0;
        stretch = 0;
        sink_gaps = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.out_byte = out_if.out_byte;
                got.first_of_message = out_if.first_of_message;
                got.last_of_message = out_if.last_of_message;
                got.message_type = out_if.message_type;
                got.message_length = out_if.message_length;
                got.error_code = out_if.error_code;
                got.error_data = out_if.error_data;
                got.last_in_run = out_if.last_in_run;
                sb.check_out_word(got);
            end
            if (stretch == 0) begin
                stretch = $urandom_range(40, 300);
                sink_gaps = $urandom_range(0, 2) != 0;
            end
            stretch--;
            if (hold > 0) begin
                hold--;
            end else if (!calm && sink_gaps && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 17);
            end
            out_if.ready <= (hold == 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid & in_if.ready) === 1'b1 || (out_if.valid & out_if.ready) === 1'b1
                    || (cfg_if.valid & cfg_if.ready) === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
